### design/tkft_pkg.sv
// tkft_pkg: shared types, command codes and defaults for the top-k fitness tracker
// used by the channel interfaces, the list cell and the top level
package tkft_pkg;

  localparam int CAPACITY_DEF = 16;

  // command codes of an input beat
  localparam logic [1:0] CMD_OFFER = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        agent_id;
    logic signed [31:0] fitness;
    logic [31:0]        complexity_bits;
    logic [3:0]         read_rank;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [3:0]         placed_rank;
    logic [4:0]         list_size;
    logic [31:0]        out_agent_id;
    logic signed [31:0] out_fitness;
    logic [31:0]        out_complexity_bits;
  } out_item_t;

  // one stored list entry
  typedef struct packed {
    logic signed [31:0] fitness;
    logic [31:0]        agent;
    logic [31:0]        complexity;
  } entry_t;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic insert;
    logic clear;
  } cell_ctl_t;

endpackage

### design/tkft_in_if.sv
// tkft_in_if: valid/ready channel carrying input beats
// depends on tkft_pkg for the payload type
interface tkft_in_if;
  import tkft_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/tkft_out_if.sv
// tkft_out_if: valid/ready channel carrying result beats
// depends on tkft_pkg for the payload type
interface tkft_out_if;
  import tkft_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/tkft_cell.sv
// tkft_cell: one rank of the sorted list, holds one entry and shifts from its left neighbor
// depends on tkft_pkg
module tkft_cell (
  input  logic                clk,
  input  logic                rst,
  input  tkft_pkg::cell_ctl_t ctl,
  input  tkft_pkg::entry_t    new_entry,
  input  tkft_pkg::entry_t    left_entry,
  input  logic                left_pos_le,
  input  logic                valid,
  output tkft_pkg::entry_t    entry,
  output logic                pos_le
);
  import tkft_pkg::*;

  // insertion point is at or before this rank
  assign pos_le = !valid || ($signed(new_entry.fitness) > $signed(entry.fitness));

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (ctl.clear) begin
      entry <= '0;
    end else if (ctl.insert) begin
      if (left_pos_le) begin
        entry <= left_entry;
      end else if (pos_le) begin
        entry <= new_entry;
      end
    end
  end
endmodule

### design/top_k_fitness_tracker_unit.sv
// top_k_fitness_tracker_unit: sorted top-k list built as a row of tkft_cell ranks
// depends on tkft_pkg, tkft_in_if, tkft_out_if and tkft_cell
// latency: a result beat is presented the cycle after its input beat is accepted
// throughput: one beat per cycle while no result is stalled; every rank compares and shifts in the same cycle
// in_ch.ready drops only while a result waits and out_ch.ready is low
// reset: synchronous, clears every entry, the size and the result valid flag
module top_k_fitness_tracker_unit #(
  parameter int CAPACITY = tkft_pkg::CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst,
  tkft_in_if.sink  in_ch,
  tkft_out_if.source out_ch
);
  import tkft_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // list size
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  entry_t              entries [CAPACITY];
  logic [CAPACITY-1:0] pos_le;
  logic [CAPACITY-1:0] first;
  logic [CAPACITY-1:0] valid;

  entry_t    new_entry;
  cell_ctl_t ctl;
  logic      in_acc;
  logic      is_offer;
  logic      do_insert;
  logic      full;
  logic [RW-1:0] placed;
  entry_t    rd_tab [16];
  entry_t    rd_entry;
  out_item_t result;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_offer    = (in_ch.data.command == CMD_OFFER);

  assign new_entry.fitness    = in_ch.data.fitness;
  assign new_entry.agent      = in_ch.data.agent_id;
  assign new_entry.complexity = in_ch.data.complexity_bits;

  // last rank says whether the offer gets in: empty slot there or beaten
  assign full      = (count == CW'(CAPACITY));
  assign do_insert = is_offer && pos_le[CAPACITY-1];

  assign ctl.insert = in_acc && do_insert;
  assign ctl.clear  = in_acc && (in_ch.data.command == CMD_CLEAR);

  // row of cells, rank 0 leftmost
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid[i] = (count > CW'(i));
    if (i == 0) begin : g_head
      assign first[i] = pos_le[i];
      tkft_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .new_entry   (new_entry),
        .left_entry  ('0),
        .left_pos_le (1'b0),
        .valid       (valid[i]),
        .entry       (entries[i]),
        .pos_le      (pos_le[i])
      );
    end else begin : g_body
      assign first[i] = pos_le[i] && !pos_le[i-1];
      tkft_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .new_entry   (new_entry),
        .left_entry  (entries[i-1]),
        .left_pos_le (pos_le[i-1]),
        .valid       (valid[i]),
        .entry       (entries[i]),
        .pos_le      (pos_le[i])
      );
    end
  end

  // rank of the insertion point, one-hot to binary
  always_comb begin
    placed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        placed = placed | RW'(i);
      end
    end
  end

  // read port covers the ranks the 4-bit field can name, zero beyond capacity
  for (genvar r = 0; r < 16; r++) begin : g_rd
    if (r < CAPACITY) begin : g_hit
      assign rd_tab[r] = entries[r];
    end else begin : g_miss
      assign rd_tab[r] = '0;
    end
  end
  assign rd_entry = rd_tab[in_ch.data.read_rank];

  always_comb begin
    count_next = count;
    if (ctl.clear) begin
      count_next = '0;
    end else if (ctl.insert && !full) begin
      count_next = count + CW'(1);
    end
  end

  always_comb begin
    result = '0;
    unique case (in_ch.data.command)
      CMD_OFFER: begin
        if (do_insert) begin
          result.accepted    = 1'b1;
          result.placed_rank = 4'(placed);
        end
      end
      CMD_CLEAR: begin
      end
      CMD_READ: begin
        result.out_agent_id        = rd_entry.agent;
        result.out_fitness         = rd_entry.fitness;
        result.out_complexity_bits = rd_entry.complexity;
      end
      default: begin
      end
    endcase
    if (in_ch.data.command == CMD_CLEAR) begin
      result.list_size = '0;
    end else begin
      result.list_size = 5'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (in_acc) begin
        count        <= count_next;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_ch.data <= result;
    end
  end

  // size never runs past capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list size above capacity");

  // a clear beat empties the list
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> (count == '0))
    else $error("clear left entries");

  // a rejected offer leaves the size alone
  a_reject_stable: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_offer && !pos_le[CAPACITY-1]) |=> $stable(count))
    else $error("rejected offer changed size");

  // a stalled result blocks the input side
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while result stalled");

  // at most one rank is flagged as the insertion point
  a_pos_monotone: assert property (@(posedge clk) disable iff (rst)
    $onehot0(first))
    else $error("more than one insertion point");
endmodule

### tb/top_k_fitness_tracker_unit_test.sv
`timescale 1ns / 1ps
// top_k_fitness_tracker_unit_test: self-checking bench for the sorted top-k fitness list
// needs tkft_pkg, tkft_in_if, tkft_out_if and top_k_fitness_tracker_unit
// a directed table first, then weighted random beats checked against a rank list model
module top_k_fitness_tracker_unit_test;
  import tkft_pkg::*;

  localparam int DEPTH = CAPACITY_DEF;
  localparam int RANDOM_BEATS = 1520;
  localparam int TAIL_CYCLES = 10;
  // command 3 is left unused by the block and must act as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // one row of the directed table; want is used only where typed is set
  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  logic clk;
  logic rst;

  tkft_in_if  in_ch();
  tkft_out_if out_ch();

  top_k_fitness_tracker_unit #(.CAPACITY(DEPTH)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the ranked list, best fitness at rank 0
  int          rank_fit[DEPTH];
  logic [31:0] rank_agent[DEPTH];
  logic [31:0] rank_cplx[DEPTH];
  int          live_count;

  // results still owed by the block, oldest first
  out_item_t   owed_results[$];
  plan_row_t   plan[$];

  int err_count;
  int n_taken, n_turned_away, n_swaps, n_reads, n_clears, n_noops;
  int send_calm, recv_calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous simulation time limit, far above the slowest legal run
  initial begin
    #20ms;
    $display("timeout: %0d results still owed", owed_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // random wait per beat, broken up by stretches at full rate
  function automatic int draw_wait(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic in_item_t mk_in(logic [1:0] cmd, logic [31:0] agent, logic [31:0] fit,
                                     logic [31:0] cplx, logic [3:0] rank);
    in_item_t it;
    it.command         = cmd;
    it.agent_id        = agent;
    it.fitness         = fit;
    it.complexity_bits = cplx;
    it.read_rank       = rank;
    return it;
  endfunction

  function automatic out_item_t mk_out(logic acc, logic [3:0] rank, logic [4:0] size,
                                       logic [31:0] agent, logic [31:0] fit, logic [31:0] cplx);
    out_item_t r;
    r.accepted            = acc;
    r.placed_rank         = rank;
    r.list_size           = size;
    r.out_agent_id        = agent;
    r.out_fitness         = fit;
    r.out_complexity_bits = cplx;
    return r;
  endfunction

  function automatic void add_row(in_item_t stim, bit typed, out_item_t want);
    plan_row_t row;
    row.stim  = stim;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  // apply one beat to the shadow list and return the result the block owes for it
  function automatic out_item_t rank_list_apply(in_item_t it);
    out_item_t r;
    int offered;
    int pos;
    int i;
    bit full;
    bit found;
    r = '0;
    offered = $signed(it.fitness);
    case (it.command)
      CMD_OFFER: begin
        full = (live_count >= DEPTH);
        if (!full || offered > rank_fit[DEPTH-1]) begin
          // first rank with strictly lower fitness, so ties keep arrival order
          pos = live_count;
          found = 1'b0;
          for (i = 0; i < live_count; i++) begin
            if (!found && offered > rank_fit[i]) begin
              pos = i;
              found = 1'b1;
            end
          end
          if (!full) live_count++;
          else n_swaps++;
          for (i = live_count - 1; i > pos; i--) begin
            rank_fit[i]   = rank_fit[i-1];
            rank_agent[i] = rank_agent[i-1];
            rank_cplx[i]  = rank_cplx[i-1];
          end
          rank_fit[pos]   = offered;
          rank_agent[pos] = it.agent_id;
          rank_cplx[pos]  = it.complexity_bits;
          r.accepted      = 1'b1;
          r.placed_rank   = pos[3:0];
          n_taken++;
        end else begin
          n_turned_away++;
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < DEPTH; i++) begin
          rank_fit[i]   = 0;
          rank_agent[i] = '0;
          rank_cplx[i]  = '0;
        end
        live_count = 0;
        n_clears++;
      end
      CMD_READ: begin
        // ranks past the size read back the zeros left there by reset or clear
        if (it.read_rank < DEPTH) begin
          r.out_agent_id        = rank_agent[it.read_rank];
          r.out_fitness         = rank_fit[it.read_rank];
          r.out_complexity_bits = rank_cplx[it.read_rank];
        end
        n_reads++;
      end
      default: n_noops++;
    endcase
    r.list_size = live_count[4:0];
    return r;
  endfunction

  // random beat, weighted toward offers so the list spends most time full
  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    int near_last;
    it.agent_id        = $urandom;
    it.complexity_bits = $urandom;
    it.read_rank       = 4'($urandom_range(0, 15));
    it.fitness         = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 70) it.command = CMD_OFFER;
    else if (pick < 72) it.command = CMD_CLEAR;
    else if (pick < 96) it.command = CMD_READ;
    else it.command = CMD_UNUSED;
    pick = $urandom_range(0, 9);
    case (pick)
      // a small pool of values produces plenty of ties
      0, 1, 2: begin
        case ($urandom_range(0, 5))
          0: it.fitness = 32'h0000_0000;
          1: it.fitness = 32'h0000_0001;
          2: it.fitness = 32'hFFFF_FFFF;
          3: it.fitness = 32'h0001_0000;
          4: it.fitness = 32'hFFFF_0000;
          default: it.fitness = 32'h0002_8000;
        endcase
      end
      // hover around the last rank to hit the full-list threshold
      3, 4: begin
        near_last = rank_fit[DEPTH-1] + $urandom_range(0, 4) - 2;
        it.fitness = near_last;
      end
      5: it.fitness = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: ;
    endcase
    return it;
  endfunction

  // present one beat, wait for the handshake, then book its expected result
  task automatic send_beat(in_item_t it, bit typed, out_item_t want);
    int gap;
    out_item_t predicted;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    predicted = rank_list_apply(it);
    owed_results.push_back(typed ? want : predicted);
  endtask

  // hold off the sender until every owed result is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  function automatic void report_diff(string field, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      if (err_count <= 10)
        $display("mismatch %s: expected %h got %h", field, exp_v, act_v);
    end
  endfunction

  // result side: random back-pressure, no more than one ready update per edge
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // result checker: every accepted result beat is matched to the oldest owed one
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (owed_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("result beat with nothing owed: %h", out_ch.data);
      end else begin
        exp_r = owed_results.pop_front();
        report_diff("accepted", 32'(exp_r.accepted), 32'(out_ch.data.accepted));
        report_diff("placed_rank", 32'(exp_r.placed_rank), 32'(out_ch.data.placed_rank));
        report_diff("list_size", 32'(exp_r.list_size), 32'(out_ch.data.list_size));
        report_diff("out_agent_id", exp_r.out_agent_id, out_ch.data.out_agent_id);
        report_diff("out_fitness", exp_r.out_fitness, out_ch.data.out_fitness);
        report_diff("out_complexity_bits", exp_r.out_complexity_bits,
                    out_ch.data.out_complexity_bits);
      end
    end
  end

  // stimulus and end of run
  initial begin
    int n;
    err_count = 0;
    live_count = 0;
    send_calm = 0;
    recv_calm = 0;
    for (n = 0; n < DEPTH; n++) begin
      rank_fit[n]   = 0;
      rank_agent[n] = '0;
      rank_cplx[n]  = '0;
    end
    rst         <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table: empty list reads, no-op command, extremes, ties, clear, full list
    add_row(mk_in(CMD_READ, '0, '0, '0, 4'd0), 1, mk_out(0, 0, 0, 0, 0, 0));
    add_row(mk_in(CMD_READ, '1, '1, '1, 4'd15), 1, mk_out(0, 0, 0, 0, 0, 0));
    add_row(mk_in(CMD_UNUSED, '1, '1, '1, 4'hF), 1, mk_out(0, 0, 0, 0, 0, 0));
    add_row(mk_in(CMD_OFFER, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 4'd0), 1,
            mk_out(1, 0, 1, 0, 0, 0));
    add_row(mk_in(CMD_OFFER, 32'h0, 32'h8000_0000, 32'h0, 4'd0), 1,
            mk_out(1, 1, 2, 0, 0, 0));
    // equal to the top entry, so it lands just behind it
    add_row(mk_in(CMD_OFFER, 32'hA5A5_5A5A, 32'h7FFF_FFFF, 32'h3F80_0000, 4'd0), 1,
            mk_out(1, 1, 3, 0, 0, 0));
    add_row(mk_in(CMD_READ, '0, '0, '0, 4'd1), 1,
            mk_out(0, 0, 3, 32'hA5A5_5A5A, 32'h7FFF_FFFF, 32'h3F80_0000));
    add_row(mk_in(CMD_READ, '0, '0, '0, 4'd3), 1, mk_out(0, 0, 3, 0, 0, 0));
    add_row(mk_in(CMD_CLEAR, '1, '1, '1, 4'hF), 1, mk_out(0, 0, 0, 0, 0, 0));
    // fill with equal fitness: each offer goes to the end
    for (n = 0; n < DEPTH; n++)
      add_row(mk_in(CMD_OFFER, 32'h100 + n, 32'h0, $urandom, 4'd0), 1,
              mk_out(1, 4'(n), 5'(n + 1), 0, 0, 0));
    // full list: equal and lower are refused, strictly better goes to the top
    add_row(mk_in(CMD_OFFER, 32'h200, 32'h0, 32'h0, 4'd0), 1, mk_out(0, 0, 16, 0, 0, 0));
    add_row(mk_in(CMD_OFFER, 32'h201, 32'hFFFF_FFFF, 32'h0, 4'd0), 1,
            mk_out(0, 0, 16, 0, 0, 0));
    add_row(mk_in(CMD_OFFER, 32'h202, 32'h0000_0001, 32'h0, 4'd0), 1,
            mk_out(1, 0, 16, 0, 0, 0));
    add_row(mk_in(CMD_READ, '0, '0, '0, 4'd15), 0, '0);

    foreach (plan[k]) send_beat(plan[k].stim, plan[k].typed, plan[k].want);

    // random part, with a full drain now and then
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 300 == 150) drain_results();
      send_beat(random_item(), 0, '0);
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (owed_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d taken offers (%0d displacing the last rank), %0d refused",
             n_taken, n_swaps, n_turned_away);
    $display("plus %0d reads, %0d clears and %0d no-op beats; %0d mismatches",
             n_reads, n_clears, n_noops, err_count);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
design/tkft_pkg.sv
design/tkft_in_if.sv
design/tkft_out_if.sv
design/tkft_cell.sv
design/top_k_fitness_tracker_unit.sv
tb/top_k_fitness_tracker_unit_test.sv
